// ----- src/grz_pkg.sv -----
// grz_pkg: shared types, constants and helpers for the node-zero reachability block
// no dependencies; compiled first
`default_nettype none

package grz_pkg;

    localparam int unsigned FieldNodes      = 32;
    localparam int unsigned MaxNodesDefault = 32;
    localparam int unsigned IdxW            = 5;
    localparam int unsigned CntW            = 6;
    localparam logic [CntW-1:0] NumNodesReset = 6'd32;

    typedef logic [FieldNodes-1:0] t_word;

    // token that walks the cell row: partial reached set and growth flag
    typedef struct packed {
        logic  vld;
        logic  grew;
        t_word acc;
    } t_token;

    // row write / clear command broadcast to every cell
    typedef struct packed {
        logic            wr_en;
        logic [IdxW-1:0] wr_idx;
        t_word           wr_bits;
        logic            clr;
    } t_row_cmd;

    typedef enum logic {
        ST_LOAD,
        ST_RUN
    } t_state;

    // ones in the low n bit positions
    function automatic t_word node_mask(input logic [CntW-1:0] n);
        t_word m;
        for (int j = 0; j < FieldNodes; j++) begin
            m[j] = (CntW'(j) < n);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- src/grz_if.sv -----
// grz_if: valid/ready channels for adjacency rows in and reachability results out
// depends on grz_pkg
`default_nettype none

interface grz_row_if;
    import grz_pkg::*;

    logic            valid;
    logic            ready;
    logic [IdxW-1:0] row_index;
    t_word           row_bits;
    logic            last_row;

    modport source (output valid, output row_index, output row_bits, output last_row,
                    input ready);
    modport sink   (input valid, input row_index, input row_bits, input last_row,
                    output ready);
endinterface

interface grz_res_if;
    import grz_pkg::*;

    logic  valid;
    logic  ready;
    logic  connected;
    t_word reached_set;

    modport source (output valid, output connected, output reached_set, input ready);
    modport sink   (input valid, input connected, input reached_set, output ready);
endinterface

`default_nettype wire

// ----- src/grz_cell.sv -----
// grz_cell: one cell of the reachability row, holds one adjacency row
// depends on grz_pkg
`default_nettype none

module grz_cell #(
    parameter int unsigned NODE = 0
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  grz_pkg::t_row_cmd i_cmd,
    input  grz_pkg::t_word    i_mask,
    input  grz_pkg::t_token   i_tok,
    output grz_pkg::t_token   o_tok
);
    import grz_pkg::*;

    t_word  r_row;
    t_token r_tok;
    t_token n_tok;
    t_word  s_contrib;

    // adjacency row storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr) begin
            r_row <= '0;
        end else if (i_cmd.wr_en && i_cmd.wr_idx == IdxW'(NODE)) begin
            r_row <= i_cmd.wr_bits;
        end
    end

    // add successors when this node is already reached
    always_comb begin
        s_contrib  = i_tok.acc[NODE] ? (r_row & i_mask) : '0;
        n_tok.vld  = i_tok.vld;
        n_tok.acc  = i_tok.acc | s_contrib;
        n_tok.grew = i_tok.grew | (n_tok.acc != i_tok.acc);
    end

    // only the valid bit needs a reset, the payload follows it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok.vld <= n_tok.vld;
        end
        r_tok.acc  <= n_tok.acc;
        r_tok.grew <= n_tok.grew;
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

// ----- src/graph_reachability_from_node_zero_top.sv -----
// graph_reachability_from_node_zero_top: loads an adjacency matrix and reports reachability
// from node 0; depends on grz_pkg, grz_if (grz_row_if, grz_res_if) and grz_cell
`default_nettype none

// channel   dir  modport            payload
// i_row     in   grz_row_if.sink    row_index[4:0], row_bits[31:0], last_row
// o_res     out  grz_res_if.source  connected, reached_set[31:0]
// i_cfg_*   in   write only         i_cfg_wdata[5:0] -> num_nodes
//
// rows are taken one word per cycle while loading and written straight into their cell
// a word with last_row set closes the matrix; the token then walks the row of
// cells, one cell per cycle, and recirculates until a whole pass adds no node;
// without an output stall this takes at most as many passes as the node count in use
// no rows are taken while the walk runs; a finished result waits in the output
// register while loading resumes, and a stalled output just keeps the token looping
// reset (synchronous, active low) clears the rows, num_nodes goes to 32

module graph_reachability_from_node_zero_top #(
    parameter int unsigned MAX_NODES = grz_pkg::MaxNodesDefault
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    grz_row_if.sink                   i_row,
    grz_res_if.source                 o_res,
    input  wire                       i_cfg_we,
    input  wire [grz_pkg::CntW-1:0]   i_cfg_wdata
);
    import grz_pkg::*;

    // cells beyond the field width could never hold a row
    localparam int unsigned Cells = (MAX_NODES < FieldNodes) ? MAX_NODES : FieldNodes;
    localparam logic [CntW-1:0] CapN = CntW'(Cells);

    // configuration
    logic [CntW-1:0] r_num_nodes;
    logic [CntW-1:0] s_eff_nodes;

    // control
    t_state   r_state;
    t_state   n_state;
    logic     r_start;
    t_word    r_mask;
    logic     s_in_ready;
    logic     s_in_acc;
    logic     s_close;
    logic     s_pass_done;
    logic     s_capture;
    t_row_cmd s_cmd;

    // cell row
    t_token           w_tok [Cells+1];
    logic [Cells-1:0] w_vlds;
    t_token           s_head;
    t_token           s_tail;

    // result register
    logic  r_res_vld;
    logic  r_res_conn;
    t_word r_res_set;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_nodes <= NumNodesReset;
        end else if (i_cfg_we) begin
            r_num_nodes <= i_cfg_wdata;
        end
    end

    // zero counts as one node, anything past the cell count saturates
    always_comb begin
        priority if (r_num_nodes == '0) begin
            s_eff_nodes = CntW'(1);
        end else if (r_num_nodes > CapN) begin
            s_eff_nodes = CapN;
        end else begin
            s_eff_nodes = r_num_nodes;
        end
    end

    assign s_in_acc    = i_row.valid && s_in_ready;
    assign s_close     = s_in_acc && i_row.last_row;
    assign s_tail      = w_tok[Cells];
    assign s_pass_done = (r_state == ST_RUN) && s_tail.vld && !s_tail.grew;
    assign s_capture   = s_pass_done && (!r_res_vld || o_res.ready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (s_close) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (s_capture) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // state outputs
    always_comb begin
        unique case (r_state)
            ST_LOAD: s_in_ready = 1'b1;
            ST_RUN:  s_in_ready = 1'b0;
            default: s_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_start <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= s_close;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_close) begin
            r_mask <= node_mask(s_eff_nodes);
        end
    end

    // row writes go in on accept, the whole store clears when a result is taken
    always_comb begin
        s_cmd.wr_en   = s_in_acc;
        s_cmd.wr_idx  = i_row.row_index;
        s_cmd.wr_bits = i_row.row_bits;
        s_cmd.clr     = s_capture;
    end

    // head of the row: fresh token with node 0 reached, or the tail looping back
    always_comb begin
        s_head.acc  = s_tail.acc;
        s_head.grew = 1'b0;
        priority if (r_start) begin
            s_head.vld = 1'b1;
            s_head.acc = t_word'(1);
        end else if (s_tail.vld && !s_capture) begin
            s_head.vld = 1'b1;
        end else begin
            s_head.vld = 1'b0;
        end
    end

    assign w_tok[0] = s_head;

    for (genvar k = 0; k < Cells; k++) begin : g_cell
        grz_cell #(
            .NODE (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (s_cmd),
            .i_mask  (r_mask),
            .i_tok   (w_tok[k]),
            .o_tok   (w_tok[k+1])
        );
        assign w_vlds[k] = w_tok[k+1].vld;
    end

    // output register, frees the row side while a result waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else if (s_capture) begin
            r_res_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_res_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_capture) begin
            r_res_conn <= (s_tail.acc == r_mask);
            r_res_set  <= s_tail.acc;
        end
    end

    assign i_row.ready       = s_in_ready;
    assign o_res.valid       = r_res_vld;
    assign o_res.connected   = r_res_conn;
    assign o_res.reached_set = r_res_set;

    // only one token ever walks the row
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_vlds))
        else $error("more than one token in the cell row");

    // no token survives once loading resumes
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |-> (w_vlds == '0))
        else $error("token left in the row while loading");

    // a taken result appears on the output next cycle
    a_capture_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_capture |=> o_res.valid)
        else $error("result lost after capture");

    // node 0 is always reached and nothing lies outside the node mask
    a_set_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_capture |-> (s_tail.acc[0] && ((s_tail.acc & ~r_mask) == '0)))
        else $error("reached set malformed");

endmodule

`default_nettype wire

// ----- tb/grz_reach_checker.sv -----
`timescale 1ns / 100ps
// grz_reach_checker: watches the row, result and node-count ports of the reachability block,
// keeps its own copy of the matrix and predicts every result; depends on grz_pkg and grz_if

module grz_reach_checker #(
    parameter int unsigned MAX_NODES = grz_pkg::MaxNodesDefault
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    grz_row_if                       i_row,
    grz_res_if                       i_res,
    input  wire                      i_cfg_we,
    input  wire [grz_pkg::CntW-1:0]  i_cfg_wdata,
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_results
);
    import grz_pkg::*;

    localparam int unsigned NodeCap     = (MAX_NODES < FieldNodes) ? MAX_NODES : FieldNodes;
    localparam int          ReportLimit = 10;

    typedef struct packed {
        logic  connected;
        t_word reached_set;
    } t_reach;

    t_word           adj_rows [FieldNodes];
    logic [CntW-1:0] node_count = NumNodesReset;
    t_reach          reach_due [$];
    int              bad_words = 0;
    int              results_seen = 0;

    // grow the visited set from node 0 until a sweep adds nothing
    function automatic t_reach reach_from_root(input logic [CntW-1:0] count);
        int unsigned n;
        int unsigned i;
        t_word       live;
        t_word       seen;
        t_word       grown;
        bit          growing;
        t_reach      r;
        n = (count == 0) ? 1 : ((count > NodeCap) ? NodeCap : count);
        live = '0;
        for (i = 0; i < n; i++) begin
            live[i] = 1'b1;
        end
        seen = t_word'(1);
        growing = 1'b1;
        while (growing) begin
            grown = seen;
            for (i = 0; i < n; i++) begin
                if (seen[i]) begin
                    grown |= adj_rows[i];
                end
            end
            grown &= live;
            growing = (grown != seen);
            seen = grown;
        end
        r.connected   = (seen == live);
        r.reached_set = seen;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reach got;
        t_reach want;
        if (!i_rst_n) begin
            node_count = NumNodesReset;
            foreach (adj_rows[k]) begin
                adj_rows[k] = '0;
            end
            reach_due.delete();
        end else begin
            if (i_cfg_we) begin
                node_count = i_cfg_wdata;
            end
            if (i_res.valid && i_res.ready) begin
                got.connected   = i_res.connected;
                got.reached_set = i_res.reached_set;
                results_seen++;
                if (reach_due.size() == 0) begin
                    bad_words++;
                    if (bad_words <= ReportLimit) begin
                        $display("%t unexpected result word: connected=%0b set=%08h",
                                 $realtime, got.connected, got.reached_set);
                    end
                end else begin
                    want = reach_due.pop_front();
                    if (got.connected !== want.connected ||
                        got.reached_set !== want.reached_set) begin
                        bad_words++;
                        if (bad_words <= ReportLimit) begin
                            $display({"%t result mismatch: expected connected=%0b set=%08h,",
                                      " got connected=%0b set=%08h"},
                                     $realtime, want.connected, want.reached_set,
                                     got.connected, got.reached_set);
                        end
                    end
                end
            end
            if (i_row.valid && i_row.ready) begin
                if (i_row.row_index < MAX_NODES) begin
                    adj_rows[i_row.row_index] = i_row.row_bits;
                end
                // closing word: predict, then the matrix starts empty again
                if (i_row.last_row) begin
                    reach_due.push_back(reach_from_root(node_count));
                    foreach (adj_rows[k]) begin
                        adj_rows[k] = '0;
                    end
                end
            end
        end
        o_pending    <= reach_due.size();
        o_fail_count <= bad_words;
        o_results    <= results_seen;
    end

endmodule

// ----- tb/graph_reachability_from_node_zero_top_tb.sv -----
`timescale 1ns / 100ps
// graph_reachability_from_node_zero_top_tb: drives adjacency rows and node counts into the
// reachability block and gives the verdict; depends on grz_pkg, grz_if and grz_reach_checker

module graph_reachability_from_node_zero_top_tb;
    import grz_pkg::*;

    localparam int unsigned MAX_NODES = MaxNodesDefault;
    localparam int ClkPeriod  = 10;
    localparam int RowTarget  = 1900;      // random row words to offer
    localparam int IdlePct    = 13;        // chance in a hundred of a gap on either side
    // quiet margin after the last result before the node count changes
    localparam int WalkCycles = 2 * FieldNodes + 8;
    // worst walk: one pass of every cell per node, plus a spare pass
    localparam int DrainCycles = 1 + (FieldNodes + 1) * FieldNodes;
    localparam int HoldCycles = 600;       // long stall of the result side
    localparam int HoldAfter  = 30;        // results taken before that stall starts

    // how the random graphs are shaped
    typedef enum logic [1:0] {
        SHAPE_SPARSE,
        SHAPE_CHAIN,
        SHAPE_DENSE
    } t_shape;

    typedef struct packed {
        logic [IdxW-1:0] row_index;
        t_word           row_bits;
        logic            last_row;
    } t_row_word;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            cfg_we = 1'b0;
    logic [CntW-1:0] cfg_wdata = '0;

    // no gaps on either side while this is set
    bit              calm = 1'b0;
    int              rows_sent = 0;
    int              graphs_sent = 0;
    logic [63:0]     counts_written = '0;

    int              fails;
    int              pending;
    int              results;

    grz_row_if row_ch ();
    grz_res_if res_ch ();

    graph_reachability_from_node_zero_top #(
        .MAX_NODES   (MAX_NODES)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_row       (row_ch),
        .o_res       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    grz_reach_checker #(
        .MAX_NODES    (MAX_NODES)
    ) reach_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_row        (row_ch),
        .i_res        (res_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fails),
        .o_pending    (pending),
        .o_results    (results)
    );

    always #(ClkPeriod / 2) clk = ~clk;

    // hard stop well beyond the slowest legal run
    initial begin
        #50ms;
        $display("timeout: run did not finish in its time limit");
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic t_row_word row_word(input int idx, input t_word bits, input logic last);
        t_row_word w;
        w.row_index = IdxW'(idx);
        w.row_bits  = bits;
        w.last_row  = last;
        return w;
    endfunction

    // offer one row word from a falling edge and hold it until the block takes it;
    // returns at the falling edge after acceptance with valid still high
    task automatic push_row(input int idx, input t_word bits, input logic last);
        while (!calm && $urandom_range(99) < IdlePct) begin
            row_ch.valid <= 1'b0;
            @(negedge clk);
        end
        row_ch.valid     <= 1'b1;
        row_ch.row_index <= IdxW'(idx);
        row_ch.row_bits  <= bits;
        row_ch.last_row  <= last;
        @(posedge clk);
        while (!row_ch.ready) @(posedge clk);
        @(negedge clk);
        rows_sent++;
    endtask

    // drop valid, let every expected result come back and the walk settle,
    // then write the node count while the block is quiet
    task automatic reconfigure(input logic [CntW-1:0] count, input bit no_gaps);
        row_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (WalkCycles) @(posedge clk);
        calm = no_gaps;
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= count;
        @(negedge clk);
        cfg_we    <= 1'b0;
        counts_written[count] = 1'b1;
    endtask

    // one graph for eff live nodes; mostly a full matrix with random shape,
    // sometimes a short run of arbitrary rows
    task automatic offer_graph(input int eff);
        t_word     adj [FieldNodes];
        int        order [FieldNodes];
        t_row_word seq [$];
        t_row_word tail;
        t_word     live;
        t_shape    shape;
        int        k;
        int        j;
        int        tmp;
        live = '0;
        for (k = 0; k < FieldNodes; k++) begin
            adj[k]   = '0;
            order[k] = k;
            if (k < eff) begin
                live[k] = 1'b1;
            end
        end
        if ($urandom_range(99) < 85) begin
            shape = t_shape'($urandom_range(2));
            // shuffle nodes above the root, the chain walks them in this order
            for (k = eff - 1; k > 1; k--) begin
                j        = $urandom_range(k, 1);
                tmp      = order[k];
                order[k] = order[j];
                order[j] = tmp;
            end
            case (shape)
                SHAPE_SPARSE: begin
                    // about two successors per node, so both verdicts turn up
                    for (k = 0; k < eff; k++) begin
                        for (j = 0; j < eff; j++) begin
                            if ($urandom_range(eff) < 2) begin
                                adj[k][j] = 1'b1;
                            end
                        end
                    end
                end
                SHAPE_CHAIN: begin
                    // scattered chain forces many sweeps; a third of them get cut
                    for (k = 1; k < eff; k++) begin
                        adj[order[k-1]][order[k]] = 1'b1;
                    end
                    if (eff > 1 && $urandom_range(2) == 0) begin
                        k = $urandom_range(eff - 1, 1);
                        adj[order[k-1]][order[k]] = 1'b0;
                    end
                end
                default: begin
                    for (k = 0; k < eff; k++) begin
                        adj[k] = $urandom;
                    end
                end
            endcase
            // edges to nodes past the count must be ignored
            if ($urandom_range(1) == 1) begin
                for (k = 0; k < eff; k++) begin
                    adj[k] |= $urandom & ~live;
                end
            end
            // rows go out in random order, with a few rewritten, dropped or out of range
            for (k = eff - 1; k > 0; k--) begin
                j        = $urandom_range(k, 0);
                tmp      = order[k];
                order[k] = order[j];
                order[j] = tmp;
            end
            for (k = 0; k < eff; k++) begin
                if ($urandom_range(99) < 8) begin
                    seq.push_back(row_word(order[k], $urandom, 1'b0));
                end
                if ($urandom_range(99) >= 5) begin
                    seq.push_back(row_word(order[k], adj[order[k]], 1'b0));
                end
                if (eff < FieldNodes && $urandom_range(99) < 10) begin
                    seq.push_back(row_word($urandom_range(FieldNodes - 1, eff), $urandom,
                                           1'b0));
                end
            end
        end else begin
            repeat ($urandom_range(6, 1)) begin
                seq.push_back(row_word($urandom_range(FieldNodes - 1), $urandom, 1'b0));
            end
        end
        if (seq.size() == 0) begin
            seq.push_back(row_word($urandom_range(eff - 1), $urandom, 1'b0));
        end
        tail = seq.pop_back();
        tail.last_row = 1'b1;
        seq.push_back(tail);
        for (k = 0; k < seq.size(); k++) begin
            push_row(seq[k].row_index, seq[k].row_bits, seq[k].last_row);
        end
        graphs_sent++;
    endtask

    // result side: random gaps, and one long stall once the run is under way
    initial begin : result_sink
        int hold_left;
        bit held;
        hold_left    = 0;
        held         = 1'b0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (!held && results >= HoldAfter) begin
                held      = 1'b1;
                hold_left = HoldCycles;
            end
            if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                res_ch.ready <= calm || ($urandom_range(99) >= IdlePct);
            end
        end
    end

    initial begin : stimulus
        logic [CntW-1:0] count;
        int              eff;
        int              phase;
        int              directed_rows;
        int              waited;
        row_ch.valid     = 1'b0;
        row_ch.row_index = '0;
        row_ch.row_bits  = '0;
        row_ch.last_row  = 1'b0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // node count still at its reset value of 32
        // lone root: nothing sent but the closing row, which has no edges
        push_row(0, '0, 1'b1);
        // root reaches everything in one row
        push_row(0, '1, 1'b1);
        // backward chain 0 -> 31 -> 30 -> 29 needs more than one sweep
        push_row(0, 32'h8000_0000, 1'b0);
        push_row(31, 32'h4000_0000, 1'b0);
        push_row(30, 32'h2000_0000, 1'b1);
        // row 0 written twice, only the later row counts
        push_row(0, '1, 1'b0);
        push_row(0, 32'h0000_0002, 1'b0);
        push_row(1, 32'h0000_0000, 1'b1);

        // single node: always connected, other rows ignored
        reconfigure(CntW'(1), 1'b0);
        push_row(5, '1, 1'b1);
        push_row(0, '1, 1'b1);

        // zero nodes behaves as one
        reconfigure(CntW'(0), 1'b0);
        push_row(31, '1, 1'b1);

        // largest field value saturates to 32 nodes
        reconfigure(CntW'(63), 1'b0);
        push_row(0, 32'h5555_5555, 1'b0);
        push_row(2, 32'hAAAA_AAAA, 1'b1);

        // two nodes: bits above the count do not help
        reconfigure(CntW'(2), 1'b0);
        push_row(0, 32'hFFFF_FFFC, 1'b1);
        push_row(1, 32'h0000_0001, 1'b0);
        push_row(0, 32'h0000_0002, 1'b1);

        // just over the limit, node 31 left out
        reconfigure(CntW'(33), 1'b0);
        push_row(0, 32'h0000_0002, 1'b0);
        push_row(1, 32'h7FFF_FFFC, 1'b1);

        // random phases, each with its own node count; mostly small graphs
        directed_rows = rows_sent;
        phase = 0;
        while (rows_sent < directed_rows + RowTarget) begin
            case (phase)
                0: count = CntW'(32);
                1: count = CntW'(1);
                2: count = CntW'(16);
                default: begin
                    tmp_pick: begin
                        int r;
                        r = $urandom_range(99);
                        if (r < 45) begin
                            count = CntW'($urandom_range(6, 1));
                        end else if (r < 70) begin
                            count = CntW'($urandom_range(16, 7));
                        end else if (r < 82) begin
                            count = CntW'($urandom_range(31, 17));
                        end else if (r < 90) begin
                            count = CntW'(32);
                        end else if (r < 95) begin
                            count = CntW'(0);
                        end else begin
                            count = CntW'($urandom_range(63, 33));
                        end
                    end
                end
            endcase
            // the third phase runs without any gaps on either side
            reconfigure(count, phase == 2);
            eff = (count == 0) ? 1 : ((count > FieldNodes) ? FieldNodes : count);
            repeat ((phase == 2) ? 8 : $urandom_range(10, 4)) begin
                offer_graph(eff);
            end
            phase++;
        end
        row_ch.valid <= 1'b0;

        // wait for the last results, then give any walk time to finish
        waited = 0;
        while (pending != 0 && waited < 4 * DrainCycles) begin
            @(posedge clk);
            waited++;
        end
        repeat (DrainCycles) @(posedge clk);

        $display("run offered %0d row words in %0d random graphs plus directed cases",
                 rows_sent, graphs_sent);
        $display("%0d results checked over %0d distinct node counts, zero to past the limit",
                 results, $countones(counts_written));
        if (pending != 0) begin
            $display("%0d expected results never arrived", pending);
        end
        if (fails == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
